### rtl/bbd_pkg.sv
// Shared constants and types of the bilinear Bayer demosaic block.
`default_nettype none

package bbd_pkg;

    // Default depth of each line store (longest supported row).
    localparam int MAX_WIDTH_DEF = 4096;

    // Field and register widths.
    localparam int PIX_W    = 16;
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Depth of the result queue, a power of two of at least four.
    localparam int OUT_DEPTH = 4;

    // Bayer layout codes of the top-left 2x2 cell.
    localparam logic [2:0] PAT_NONE = 3'd0;
    localparam logic [2:0] PAT_GRBG = 3'd1;
    localparam logic [2:0] PAT_GBRG = 3'd2;
    localparam logic [2:0] PAT_RGGB = 3'd3;
    localparam logic [2:0] PAT_BGGR = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

    // Register values after reset.
    localparam logic [2:0]          PATTERN_RST = PAT_RGGB;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST   = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = 16'd480;

    // One RGB result.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_pixel;

    // Per-item control carried from the input stage to the window stage.
    typedef struct packed {
        logic [PIX_W-1:0] value;      // sample, zero for flush or padding row
        logic             first_row;  // row 0: upper store gets zero
        logic             col_zero;   // first column: window restarts
        logic             emit_a;     // result for the previous column
        logic             emit_b;     // extra result at the end of a row
        logic             end_a;      // emit_a is the frame's last pixel
        logic             end_b;      // emit_b is the frame's last pixel
        logic             y_odd;      // output row is odd
        logic             x_odd;      // output column of emit_a is odd
        logic             fwd;        // line store data comes from the bypass
    } t_item;

endpackage

`default_nettype wire

### rtl/bbd_line_store.sv
// Upper and middle line stores with a clearing pass after reset.
`default_nettype none

module bbd_line_store #(
    parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  wire logic [bbd_pkg::PIX_W-1:0]     i_wr_up,
    input  wire logic [bbd_pkg::PIX_W-1:0]     i_wr_mid,
    output logic      [bbd_pkg::PIX_W-1:0]     o_rd_up,
    output logic      [bbd_pkg::PIX_W-1:0]     o_rd_mid,
    output logic                               o_busy
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [bbd_pkg::PIX_W-1:0] r_upper_mem  [MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0] r_middle_mem [MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0] r_rd_up;
    logic [bbd_pkg::PIX_W-1:0] r_rd_mid;
    logic                      r_busy;
    logic [AW-1:0]             r_clr_addr;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [bbd_pkg::PIX_W-1:0] mem_wup;
    logic [bbd_pkg::PIX_W-1:0] mem_wmid;

    // While the clearing pass runs it owns the write port.
    always_comb begin
        mem_we    = r_busy | i_wr_en;
        mem_waddr = r_busy ? r_clr_addr : i_wr_addr;
        mem_wup   = r_busy ? '0 : i_wr_up;
        mem_wmid  = r_busy ? '0 : i_wr_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_upper_mem[mem_waddr]  <= mem_wup;
            r_middle_mem[mem_waddr] <= mem_wmid;
        end
        if (i_rd_en) begin
            r_rd_up  <= r_upper_mem[i_rd_addr];
            r_rd_mid <= r_middle_mem[i_rd_addr];
        end
    end

    assign o_rd_up  = r_rd_up;
    assign o_rd_mid = r_rd_mid;
    assign o_busy   = r_busy;

`ifndef NO_ASSERTIONS
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !r_busy)
        else $error("line store written during clearing pass");
`endif

endmodule

`default_nettype wire

### rtl/bbd_window.sv
// 3x3 window registers and the bilinear interpolation of its center.
`default_nettype none

module bbd_window (
    input  wire logic                      i_clk,
    input  wire logic                      i_adv,
    input  wire bbd_pkg::t_item            i_item,
    input  wire logic [bbd_pkg::PIX_W-1:0] i_up,
    input  wire logic [bbd_pkg::PIX_W-1:0] i_mid,
    input  wire logic [2:0]                i_pattern,
    output bbd_pkg::t_pixel                o_pix_a,
    output bbd_pkg::t_pixel                o_pix_b
);

    // Window index is row*3 + column, column 2 holds the newest sample.
    logic [8:0][bbd_pkg::PIX_W-1:0] r_win;
    logic [8:0][bbd_pkg::PIX_W-1:0] n_win;
    logic [8:0][bbd_pkg::PIX_W-1:0] win_end;

    function automatic logic [2:0] flip_row(input logic [2:0] p);
        logic [2:0] f;
        unique case (p)
            bbd_pkg::PAT_GRBG: f = bbd_pkg::PAT_BGGR;
            bbd_pkg::PAT_BGGR: f = bbd_pkg::PAT_GRBG;
            bbd_pkg::PAT_GBRG: f = bbd_pkg::PAT_RGGB;
            bbd_pkg::PAT_RGGB: f = bbd_pkg::PAT_GBRG;
            default:           f = p;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] flip_col(input logic [2:0] p);
        logic [2:0] f;
        unique case (p)
            bbd_pkg::PAT_GRBG: f = bbd_pkg::PAT_RGGB;
            bbd_pkg::PAT_RGGB: f = bbd_pkg::PAT_GRBG;
            bbd_pkg::PAT_GBRG: f = bbd_pkg::PAT_BGGR;
            bbd_pkg::PAT_BGGR: f = bbd_pkg::PAT_GBRG;
            default:           f = p;
        endcase
        return f;
    endfunction

    function automatic bbd_pkg::t_pixel interp(
        input logic [8:0][bbd_pkg::PIX_W-1:0] q,
        input logic [2:0]                     pat,
        input logic                           y_odd,
        input logic                           x_odd,
        input logic                           last
    );
        logic [bbd_pkg::PIX_W+1:0] cross_sum;
        logic [bbd_pkg::PIX_W+1:0] diag_sum;
        logic [bbd_pkg::PIX_W:0]   vert_sum;
        logic [bbd_pkg::PIX_W:0]   horz_sum;
        logic [bbd_pkg::PIX_W-1:0] cross_avg;
        logic [bbd_pkg::PIX_W-1:0] diag_avg;
        logic [bbd_pkg::PIX_W-1:0] vert_avg;
        logic [bbd_pkg::PIX_W-1:0] horz_avg;
        logic [2:0]                site;
        bbd_pkg::t_pixel           p;
        vert_sum  = {1'b0, q[1]} + {1'b0, q[7]};
        horz_sum  = {1'b0, q[3]} + {1'b0, q[5]};
        cross_sum = {1'b0, vert_sum} + {1'b0, horz_sum};
        diag_sum  = {2'b00, q[0]} + {2'b00, q[2]} + {2'b00, q[6]} + {2'b00, q[8]};
        vert_avg  = vert_sum[bbd_pkg::PIX_W:1];
        horz_avg  = horz_sum[bbd_pkg::PIX_W:1];
        cross_avg = cross_sum[bbd_pkg::PIX_W+1:2];
        diag_avg  = diag_sum[bbd_pkg::PIX_W+1:2];
        site = pat;
        if (y_odd) begin
            site = flip_row(site);
        end
        if (x_odd) begin
            site = flip_col(site);
        end
        unique case (site)
            bbd_pkg::PAT_BGGR: begin
                p.red = diag_avg;  p.green = cross_avg; p.blue = q[4];
            end
            bbd_pkg::PAT_GBRG: begin
                p.red = vert_avg;  p.green = q[4];      p.blue = horz_avg;
            end
            bbd_pkg::PAT_GRBG: begin
                p.red = horz_avg;  p.green = q[4];      p.blue = vert_avg;
            end
            default: begin
                // Red sites, and also the none pattern and unused codes.
                p.red = q[4];      p.green = cross_avg; p.blue = diag_avg;
            end
        endcase
        p.frame_end = last;
        return p;
    endfunction

    // New column enters on the right; the first column of a row starts
    // from zero padding on the left.
    always_comb begin
        if (i_item.col_zero) begin
            n_win    = '0;
            n_win[2] = i_up;
            n_win[5] = i_mid;
            n_win[8] = i_item.value;
        end else begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = i_up;
            n_win[3] = r_win[4];
            n_win[4] = r_win[5];
            n_win[5] = i_mid;
            n_win[6] = r_win[7];
            n_win[7] = r_win[8];
            n_win[8] = i_item.value;
        end
    end

    // At the end of a row the window moves once more over the zero border.
    always_comb begin
        win_end[0] = n_win[1];
        win_end[1] = n_win[2];
        win_end[2] = '0;
        win_end[3] = n_win[4];
        win_end[4] = n_win[5];
        win_end[5] = '0;
        win_end[6] = n_win[7];
        win_end[7] = n_win[8];
        win_end[8] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

    assign o_pix_a = interp(n_win, i_pattern, i_item.y_odd, i_item.x_odd, i_item.end_a);
    assign o_pix_b = interp(win_end, i_pattern, i_item.y_odd, !i_item.x_odd, i_item.end_b);

endmodule

`default_nettype wire

### rtl/bbd_out_fifo.sv
// Result queue: up to two results in per cycle, one out unless stalled.
`default_nettype none

module bbd_out_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_a,
    input  wire logic            i_push_b,
    input  wire bbd_pkg::t_pixel i_pix_a,
    input  wire bbd_pkg::t_pixel i_pix_b,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output bbd_pkg::t_pixel      o_pix
);

    localparam int DEPTH = bbd_pkg::OUT_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = PW + 1;

    bbd_pkg::t_pixel r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;

    logic            pop;
    logic [CNTW-1:0] push_cnt;
    logic [PW-1:0]   wr_addr_b;

    always_comb begin
        pop       = (r_count != '0) && !i_stall;
        push_cnt  = CNTW'(i_push_a) + CNTW'(i_push_b);
        wr_addr_b = i_push_a ? r_wr_ptr + PW'(1) : r_wr_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_cnt[PW-1:0];
            r_rd_ptr <= r_rd_ptr + PW'(pop);
            r_count  <= r_count + push_cnt - CNTW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr_ptr] <= i_pix_a;
        end
        if (i_push_b) begin
            r_mem[wr_addr_b] <= i_pix_b;
        end
    end

    // Room for two results, judged on the registered count only.
    assign o_room  = r_count <= CNTW'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_pix   = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("result queue count beyond depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_a || i_push_b) |-> (r_count <= CNTW'(DEPTH - 2)))
        else $error("result pushed without room");
`endif

endmodule

`default_nettype wire

### rtl/bayer_bilinear_demosaic.sv
// Top level of the bilinear Bayer demosaic: registers, counters and input stage.
`default_nettype none

// Raw Bayer samples enter in raster order on the input channel, one transfer
// per pixel, followed by one padding row of image_width flush items. Each
// transfer outside the first row and column gives RGB results for the pixel
// one row up and one column to the left; the last item of a row also gives
// the pixel above it, so the output stream is one RGB pixel per raw pixel,
// with frame_end on the last. Throughput is one input transfer per clock
// while the input is not stalled. The two line stores are read at the column
// of the accepted item and written when the waiting item moves on and its
// results enter the result queue, whose registered entries drive the output.
// The result queue holds four entries; outside the clearing pass the input
// stalls only while it holds more than two, which happens when the receiver
// stalls the output channel. After reset the line stores are cleared one
// column per cycle and the input stalls meanwhile; configuration writes are
// taken at any time (ready is always high) but take effect safely only while
// idle. Reset values: RGGB pattern, 640 columns, 480 rows.

module bayer_bilinear_demosaic #(
    parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // raw pixel input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic [bbd_pkg::PIX_W-1:0]      i_pixel_value,
    // RGB result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [bbd_pkg::PIX_W-1:0]      o_red,
    output logic      [bbd_pkg::PIX_W-1:0]      o_green,
    output logic      [bbd_pkg::PIX_W-1:0]      o_blue,
    output logic                                o_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    // Wide enough for a column count plus one and for the width register.
    localparam int CW = (AW + 1 > bbd_pkg::WIDTH_W) ? AW + 1 : bbd_pkg::WIDTH_W;
    localparam int RW = bbd_pkg::ROW_W;

    // Configuration registers.
    logic [2:0]                     r_pattern;
    logic [bbd_pkg::WIDTH_W-1:0]    r_width;
    logic [bbd_pkg::HEIGHT_W-1:0]   r_height;

    // Position of the next input pixel.
    logic [AW-1:0]                  r_col;
    logic [RW-1:0]                  r_row;

    // Item waiting for its line store data.
    logic                           r_a_valid;
    logic [AW-1:0]                  r_a_addr;
    bbd_pkg::t_item                 r_a;

    // Bypass of the last line store write, for a read of the same column
    // issued together with that write (one-column rows).
    logic [bbd_pkg::PIX_W-1:0]      r_fwd_up;
    logic [bbd_pkg::PIX_W-1:0]      r_fwd_mid;

    logic [CW-1:0]                  width_ext;
    logic [CW-1:0]                  max_w;
    logic [CW-1:0]                  w_eff;
    logic [RW-1:0]                  h_eff;
    logic [CW-1:0]                  col_ext;
    logic [CW-1:0]                  col_inc;
    logic                           pad_row;
    logic                           row_end;
    logic                           last_row;
    logic                           in_acc;
    logic                           a_adv;
    logic                           fifo_room;
    logic                           clr_busy;
    bbd_pkg::t_item                 n_item;

    logic [bbd_pkg::PIX_W-1:0]      rd_up;
    logic [bbd_pkg::PIX_W-1:0]      rd_mid;
    logic [bbd_pkg::PIX_W-1:0]      up_eff;
    logic [bbd_pkg::PIX_W-1:0]      mid_eff;
    logic [bbd_pkg::PIX_W-1:0]      wr_up;

    bbd_pkg::t_pixel                pix_a;
    bbd_pkg::t_pixel                pix_b;
    bbd_pkg::t_pixel                pix_out;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= bbd_pkg::PATTERN_RST;
            r_width   <= bbd_pkg::WIDTH_RST;
            r_height  <= bbd_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bbd_pkg::CFG_PATTERN: r_pattern <= i_cfg_data[2:0];
                bbd_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[bbd_pkg::WIDTH_W-1:0];
                bbd_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[bbd_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: width clamped to 1..MAX_WIDTH, height at least 1.
    always_comb begin
        width_ext = CW'(r_width);
        max_w     = CW'(MAX_WIDTH);
        if (width_ext == '0) begin
            w_eff = CW'(1);
        end else if (width_ext > max_w) begin
            w_eff = max_w;
        end else begin
            w_eff = width_ext;
        end
        h_eff = (r_height == '0) ? RW'(1) : RW'(r_height);
    end

    // Position decode of the item on the input port.
    always_comb begin
        col_ext  = CW'(r_col);
        col_inc  = col_ext + CW'(1);
        pad_row  = r_row >= h_eff;
        row_end  = col_inc >= w_eff;
        last_row = r_row == h_eff;

        n_item.value     = (i_action || pad_row) ? '0 : i_pixel_value;
        n_item.first_row = r_row == '0;
        n_item.col_zero  = r_col == '0;
        n_item.emit_a    = (r_row != '0) && (r_col != '0);
        n_item.emit_b    = row_end && (r_row != '0);
        n_item.end_a     = last_row && (col_ext == w_eff);
        n_item.end_b     = last_row && (col_inc == w_eff);
        n_item.y_odd     = !r_row[0];
        n_item.x_odd     = !r_col[0];
        n_item.fwd       = a_adv && (r_col == r_a_addr);
    end

    // The waiting item moves on when the result queue can take two results;
    // after clearing, a new item enters when the input stage is free or moving on.
    assign a_adv      = r_a_valid && fifo_room;
    assign o_in_stall = clr_busy || (r_a_valid && !fifo_room);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= pad_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a      <= n_item;
            r_a_addr <= r_col;
        end
        if (a_adv) begin
            r_fwd_up  <= wr_up;
            r_fwd_mid <= r_a.value;
        end
    end

    // The middle store's old content moves up to the upper store.
    always_comb begin
        up_eff  = r_a.fwd ? r_fwd_up  : rd_up;
        mid_eff = r_a.fwd ? r_fwd_mid : rd_mid;
        wr_up   = r_a.first_row ? '0 : mid_eff;
    end

    bbd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_addr),
        .i_wr_up   (wr_up),
        .i_wr_mid  (r_a.value),
        .o_rd_up   (rd_up),
        .o_rd_mid  (rd_mid),
        .o_busy    (clr_busy)
    );

    bbd_window u_window (
        .i_clk     (i_clk),
        .i_adv     (a_adv),
        .i_item    (r_a),
        .i_up      (up_eff),
        .i_mid     (mid_eff),
        .i_pattern (r_pattern),
        .o_pix_a   (pix_a),
        .o_pix_b   (pix_b)
    );

    bbd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (a_adv && r_a.emit_a),
        .i_push_b (a_adv && r_a.emit_b),
        .i_pix_a  (pix_a),
        .i_pix_b  (pix_b),
        .o_room   (fifo_room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_pix    (pix_out)
    );

    assign o_red       = pix_out.red;
    assign o_green     = pix_out.green;
    assign o_blue      = pix_out.blue;
    assign o_frame_end = pix_out.frame_end;

`ifndef NO_ASSERTIONS
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && row_end) |=> (r_col == '0))
        else $error("column count did not wrap at row end");
    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.fwd) |-> (r_a_addr == $past(r_a_addr)))
        else $error("bypass used for a different column");
`endif

endmodule

`default_nettype wire
